// ----- hdl/assert_macros.svh -----
// assertion macros shared by the canceller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define LLNC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// implication checked in the next cycle
`define LLNC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ----- hdl/llnc_pkg.sv -----
// types and constants of the leaky lms noise canceller
package llnc_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int WEIGHT_W   = 48;
   localparam int LEAK_W     = 16;
   localparam int SHIFT_W    = 6;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // fixed point alignment
   localparam int FRAC_SHIFT = 16;  // weight*ref is q.32, sum is kept in q.16
   localparam int LEAK_FRAC  = 15;  // leak coefficient is q1.15
   localparam int GRAD_ALIGN = 32;  // error*ref lifted to weight scale

   // operating modes
   localparam logic [MODE_W-1:0] MODE_ADAPT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PASS  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_OFF   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP = 2'd2;

   // register reset values
   localparam logic [MODE_W-1:0]  MODE_RESET = MODE_ADAPT;
   localparam logic [LEAK_W-1:0]  LEAK_RESET = 16'd16384;
   localparam logic [SHIFT_W-1:0] STEP_RESET = 6'd30;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_WAIT
   } state_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] reference_sample;
      logic signed [SAMPLE_W-1:0] error_sample;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_sample;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_payload_type;

   typedef struct packed {
      logic tap_en;
      logic weight_en;
   } cell_ctrl_type;

   typedef struct packed {
      logic clear;
      logic valid;
   } upd_ctrl_type;

endpackage

// ----- hdl/llnc_stream_if.sv -----
// valid/ready channel carrying one payload per transaction
interface llnc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/leaky_lms_noise_canceller.sv -----
// top level of the leaky lms adaptive noise canceller
//
// Channels: req_chan takes one reference/error sample pair per transaction,
// rsp_chan returns one saturated anti-noise sample per request, and csr_chan
// writes the mode, leak coefficient and step shift registers (always ready;
// the user must write them only while the block is idle, the block itself
// does not enforce this).
// Adaptive mode: the taps and weights sit in a row of cells that rotates one
// tap per cycle through a shared update unit with two pipeline stages. The
// result is registered once the rotation and the pipeline drain are through,
// and a new request is taken only once the sequencer is back in idle.
// Passthrough and off modes answer in the cycle after the request and take
// one item per cycle while the result register drains.
// Reset clears taps and weights at once and loads the register defaults.
// When the receiver stalls, the result waits in the output register; an
// adaptive request is still taken and computed, and then holds until the
// output register is free.
`include "assert_macros.svh"

module leaky_lms_noise_canceller #(
   parameter int TAP_COUNT = 30
) (
   input  logic           clock,
   input  logic           reset,
   llnc_stream_if.sink    req_chan,
   llnc_stream_if.source  rsp_chan,
   llnc_stream_if.sink    csr_chan
);

   localparam int S_W   = llnc_pkg::SAMPLE_W;
   localparam int W_W   = llnc_pkg::WEIGHT_W;
   localparam int CNT_W = $clog2(TAP_COUNT + 2);
   localparam logic [CNT_W-1:0] RING_END = CNT_W'(TAP_COUNT);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TAP_COUNT + 1);

   llnc_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [S_W-1:0] rsp_data_ff, rsp_data_in;
   logic [llnc_pkg::MODE_W-1:0]  mode_ff, mode_in;
   logic [llnc_pkg::LEAK_W-1:0]  leak_ff, leak_in;
   logic [llnc_pkg::SHIFT_W-1:0] step_ff, step_in;

   logic accept, out_free, busy, ring_phase, line_phase;
   logic signed [S_W-1:0] direct_sample;

   llnc_pkg::cell_ctrl_type cell_ctrl [TAP_COUNT];
   logic signed [S_W-1:0] prev_ref [TAP_COUNT];
   logic signed [S_W-1:0] prev_err [TAP_COUNT];
   logic signed [W_W-1:0] prev_weight [TAP_COUNT];
   logic signed [S_W-1:0] ref_tap [TAP_COUNT];
   logic signed [S_W-1:0] err_tap [TAP_COUNT];
   logic signed [W_W-1:0] weight_tap [TAP_COUNT];

   llnc_pkg::upd_ctrl_type upd_ctrl;
   logic signed [W_W-1:0]  upd_weight;
   logic signed [S_W-1:0]  upd_sample;

   // handshakes
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == llnc_pkg::ST_IDLE) &&
                           ((mode_ff == llnc_pkg::MODE_ADAPT) || out_free);
   assign accept         = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.payload.out_sample = rsp_data_ff;

   // configuration register writes
   always_comb begin
      mode_in = mode_ff;
      leak_in = leak_ff;
      step_in = step_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.payload.index)
            llnc_pkg::CSR_MODE: mode_in = csr_chan.payload.data[llnc_pkg::MODE_W-1:0];
            llnc_pkg::CSR_LEAK: leak_in = csr_chan.payload.data[llnc_pkg::LEAK_W-1:0];
            llnc_pkg::CSR_STEP: step_in = csr_chan.payload.data[llnc_pkg::SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= llnc_pkg::MODE_RESET;
         leak_ff <= llnc_pkg::LEAK_RESET;
         step_ff <= llnc_pkg::STEP_RESET;
      end else begin
         mode_ff <= mode_in;
         leak_ff <= leak_in;
         step_ff <= step_in;
      end
   end

   // result of the non-adaptive modes
   always_comb begin
      case (mode_ff)
         llnc_pkg::MODE_PASS: direct_sample = req_chan.payload.reference_sample;
         llnc_pkg::MODE_OFF:  direct_sample = '0;
         default:             direct_sample = '0;
      endcase
   end

   // sequencer: rotate the ring, shift the delay line, drain the pipeline
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         llnc_pkg::ST_IDLE: begin
            if (accept) begin
               if (mode_ff == llnc_pkg::MODE_ADAPT) begin
                  state_in = llnc_pkg::ST_BUSY;
                  count_in = '0;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = direct_sample;
               end
            end
         end
         llnc_pkg::ST_BUSY: begin
            count_in = count_ff + 1'b1;
            if (count_ff == LAST_CNT) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = upd_sample;
                  state_in     = llnc_pkg::ST_IDLE;
               end else begin
                  state_in = llnc_pkg::ST_WAIT;
               end
            end
         end
         llnc_pkg::ST_WAIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = upd_sample;
               state_in     = llnc_pkg::ST_IDLE;
            end
         end
         default: state_in = llnc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= llnc_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // phases of an adaptive item
   assign busy       = (state_ff == llnc_pkg::ST_BUSY);
   assign ring_phase = busy && (count_ff < RING_END);
   assign line_phase = busy && (count_ff == RING_END);

   // cell wiring: head takes the new sample or closes the ring
   always_comb begin
      cell_ctrl[0].tap_en    = accept || ring_phase;
      cell_ctrl[0].weight_en = busy;
      prev_ref[0]    = accept ? req_chan.payload.reference_sample : ref_tap[TAP_COUNT-1];
      prev_err[0]    = accept ? req_chan.payload.error_sample : err_tap[TAP_COUNT-1];
      prev_weight[0] = upd_weight;
      for (int i = 1; i < TAP_COUNT; i++) begin
         cell_ctrl[i].tap_en    = ring_phase || line_phase;
         cell_ctrl[i].weight_en = busy;
         prev_ref[i]    = ref_tap[i-1];
         prev_err[i]    = err_tap[i-1];
         prev_weight[i] = weight_tap[i-1];
      end
   end

   for (genvar g = 0; g < TAP_COUNT; g++) begin : g_cell
      llnc_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl[g]),
         .prev_ref    (prev_ref[g]),
         .prev_err    (prev_err[g]),
         .prev_weight (prev_weight[g]),
         .ref_out     (ref_tap[g]),
         .err_out     (err_tap[g]),
         .weight_out  (weight_tap[g])
      );
   end

   // update unit sees the tail cell
   assign upd_ctrl.clear = accept;
   assign upd_ctrl.valid = ring_phase;

   llnc_update #(
      .TAP_COUNT (TAP_COUNT)
   ) u_update (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (upd_ctrl),
      .weight_in  (weight_tap[TAP_COUNT-1]),
      .ref_tap    (ref_tap[TAP_COUNT-1]),
      .err_tap    (err_tap[TAP_COUNT-1]),
      .leak_coef  (leak_ff),
      .step_shift (step_ff),
      .weight_out (upd_weight),
      .out_sample (upd_sample)
   );

   // sequencer checks
   `LLNC_ASSERT_NEXT(a_adapt_starts, clock, reset, accept && (mode_ff == llnc_pkg::MODE_ADAPT), (state_ff == llnc_pkg::ST_BUSY) && (count_ff == '0))
   `LLNC_ASSERT_NEXT(a_busy_holds, clock, reset, busy && (count_ff != LAST_CNT), state_ff == llnc_pkg::ST_BUSY)
   `LLNC_ASSERT_SAME(a_count_bound, clock, reset, busy, count_ff <= LAST_CNT)

endmodule

// ----- hdl/llnc_cell.sv -----
// one tap cell: reference tap, error tap and weight, loaded from its neighbor
module llnc_cell (
   input  logic                                     clock,
   input  logic                                     reset,
   input  llnc_pkg::cell_ctrl_type                  ctrl,
   input  logic signed [llnc_pkg::SAMPLE_W-1:0]     prev_ref,
   input  logic signed [llnc_pkg::SAMPLE_W-1:0]     prev_err,
   input  logic signed [llnc_pkg::WEIGHT_W-1:0]     prev_weight,
   output logic signed [llnc_pkg::SAMPLE_W-1:0]     ref_out,
   output logic signed [llnc_pkg::SAMPLE_W-1:0]     err_out,
   output logic signed [llnc_pkg::WEIGHT_W-1:0]     weight_out
);

   logic signed [llnc_pkg::SAMPLE_W-1:0] ref_ff, ref_in;
   logic signed [llnc_pkg::SAMPLE_W-1:0] err_ff, err_in;
   logic signed [llnc_pkg::WEIGHT_W-1:0] weight_ff, weight_in;

   // take the neighbor's taps and weight when enabled
   always_comb begin
      ref_in    = ctrl.tap_en ? prev_ref : ref_ff;
      err_in    = ctrl.tap_en ? prev_err : err_ff;
      weight_in = ctrl.weight_en ? prev_weight : weight_ff;
   end

   // tap and weight state, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff    <= '0;
         err_ff    <= '0;
         weight_ff <= '0;
      end else begin
         ref_ff    <= ref_in;
         err_ff    <= err_in;
         weight_ff <= weight_in;
      end
   end

   assign ref_out    = ref_ff;
   assign err_out    = err_ff;
   assign weight_out = weight_ff;

endmodule

// ----- hdl/llnc_update.sv -----
// shared tap unit: filter accumulate and leaky lms weight update, one tap per cycle
module llnc_update #(
   parameter int TAP_COUNT = 30
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  llnc_pkg::upd_ctrl_type                   ctrl,
   input  logic signed [llnc_pkg::WEIGHT_W-1:0]     weight_in,
   input  logic signed [llnc_pkg::SAMPLE_W-1:0]     ref_tap,
   input  logic signed [llnc_pkg::SAMPLE_W-1:0]     err_tap,
   input  logic [llnc_pkg::LEAK_W-1:0]              leak_coef,
   input  logic [llnc_pkg::SHIFT_W-1:0]             step_shift,
   output logic signed [llnc_pkg::WEIGHT_W-1:0]     weight_out,
   output logic signed [llnc_pkg::SAMPLE_W-1:0]     out_sample
);

   localparam int W_W    = llnc_pkg::WEIGHT_W;
   localparam int S_W    = llnc_pkg::SAMPLE_W;
   localparam int FRAC   = llnc_pkg::FRAC_SHIFT;
   localparam int WR_W   = W_W + S_W;                       // weight * ref
   localparam int WL_W   = W_W + llnc_pkg::LEAK_W + 1;      // weight * leak
   localparam int ER_W   = 2 * S_W;                         // error * ref
   localparam int TERM_W = WR_W - FRAC;
   localparam int LK_W   = WL_W - llnc_pkg::LEAK_FRAC;
   localparam int GR_W   = ER_W + llnc_pkg::GRAD_ALIGN;
   localparam int SUM_W  = GR_W + 1;
   localparam int ACC_W  = TERM_W + $clog2(TAP_COUNT);
   localparam int Q_W    = ACC_W - FRAC;

   logic signed [WR_W-1:0]   prod_wr_ff, prod_wr_in;
   logic signed [WL_W-1:0]   prod_wl_ff, prod_wl_in;
   logic signed [ER_W-1:0]   prod_er_ff, prod_er_in;
   logic                     valid1_ff, valid1_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [LK_W-1:0]   leaked_ff, leaked_in;
   logic signed [GR_W-1:0]   grad_ff, grad_in;
   logic signed [llnc_pkg::LEAK_W:0] leak_s;
   logic signed [TERM_W-1:0] term;
   logic signed [SUM_W-1:0]  sum;
   logic signed [Q_W-1:0]    quot;
   logic                     round_up;

   // stage 1: the three products
   always_comb begin
      leak_s     = $signed({1'b0, leak_coef});
      prod_wr_in = weight_in * ref_tap;
      prod_wl_in = weight_in * leak_s;
      prod_er_in = err_tap * ref_tap;
      valid1_in  = ctrl.valid;
   end

   // stage 2: floor shifts, gradient scaling and accumulation
   always_comb begin
      term      = prod_wr_ff[WR_W-1:FRAC];
      leaked_in = prod_wl_ff[WL_W-1:llnc_pkg::LEAK_FRAC];
      grad_in   = $signed({prod_er_ff, {llnc_pkg::GRAD_ALIGN{1'b0}}}) >>> step_shift;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (valid1_ff) begin
         acc_in = acc_ff + ACC_W'(term);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_wr_ff <= prod_wr_in;
      prod_wl_ff <= prod_wl_in;
      prod_er_ff <= prod_er_in;
      leaked_ff  <= leaked_in;
      grad_ff    <= grad_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         acc_ff    <= '0;
      end else begin
         valid1_ff <= valid1_in;
         acc_ff    <= acc_in;
      end
   end

   // new weight: leaked weight plus gradient, saturated to the weight range
   always_comb begin
      sum = SUM_W'(leaked_ff) + SUM_W'(grad_ff);
      if ((&sum[SUM_W-1:W_W-1]) || !(|sum[SUM_W-1:W_W-1])) begin
         weight_out = sum[W_W-1:0];
      end else if (sum[SUM_W-1]) begin
         weight_out = {1'b1, {(W_W-1){1'b0}}};
      end else begin
         weight_out = {1'b0, {(W_W-1){1'b1}}};
      end
   end

   // filter output: q.16 sum truncated toward zero, saturated to a sample
   always_comb begin
      round_up = acc_ff[ACC_W-1] && (|acc_ff[FRAC-1:0]);
      quot     = acc_ff[ACC_W-1:FRAC] + $signed(Q_W'(round_up));
      if ((&quot[Q_W-1:S_W-1]) || !(|quot[Q_W-1:S_W-1])) begin
         out_sample = quot[S_W-1:0];
      end else if (quot[Q_W-1]) begin
         out_sample = {1'b1, {(S_W-1){1'b0}}};
      end else begin
         out_sample = {1'b0, {(S_W-1){1'b1}}};
      end
   end

endmodule

// ----- tb/llnc_scoreboard_pkg.sv -----
// scoreboard with a bit-exact predictor of the leaky lms noise canceller
package llnc_scoreboard_pkg;
   import llnc_pkg::*;

   localparam int TB_TAP_COUNT = 30;

   // codes the block has no name for but must tolerate
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;

   // wide signed range used for all intermediate arithmetic
   localparam logic signed [79:0] WEIGHT_MAX = (80'sd1 <<< (WEIGHT_W - 1)) - 80'sd1;
   localparam logic signed [79:0] WEIGHT_MIN = -(80'sd1 <<< (WEIGHT_W - 1));
   localparam logic signed [79:0] OUT_MAX    = 80'sd32767;
   localparam logic signed [79:0] OUT_MIN    = -80'sd32768;

   class anti_noise_scoreboard;
      logic signed [SAMPLE_W-1:0] ref_line [TB_TAP_COUNT];
      logic signed [SAMPLE_W-1:0] err_line [TB_TAP_COUNT];
      logic signed [WEIGHT_W-1:0] weights [TB_TAP_COUNT];
      logic [MODE_W-1:0]          mode;
      logic [LEAK_W-1:0]          leak_coef;
      logic [SHIFT_W-1:0]         step_shift;
      logic signed [SAMPLE_W-1:0] expected_out [$];
      int                         error_count;

      function new();
         for (int i = 0; i < TB_TAP_COUNT; i++) begin
            ref_line[i] = '0;
            err_line[i] = '0;
            weights[i]  = '0;
         end
         mode        = MODE_RESET;
         leak_coef   = LEAK_RESET;
         step_shift  = STEP_RESET;
         error_count = 0;
      endfunction

      task report(string msg);
         error_count++;
         if (error_count <= 40) $display("mismatch: %s", msg);
      endtask

      // register write as seen on the csr channel
      function void write_reg(csr_payload_type p);
         case (p.index)
            CSR_MODE: mode = p.data[MODE_W-1:0];
            CSR_LEAK: leak_coef = p.data[LEAK_W-1:0];
            CSR_STEP: step_shift = p.data[SHIFT_W-1:0];
            default: ;
         endcase
      endfunction

      // one filter step: output from old weights, leaky update, tap shift in adaptive mode; reference or zero otherwise
      function logic signed [SAMPLE_W-1:0] predict_out_sample(req_payload_type p);
         logic signed [79:0] acc, w, r, e, leaked, grad, nw, res;
         ref_line[0] = p.reference_sample;
         err_line[0] = p.error_sample;
         if (mode == MODE_ADAPT) begin
            acc = '0;
            for (int i = 0; i < TB_TAP_COUNT; i++) begin
               w = weights[i];
               r = ref_line[i];
               e = err_line[i];
               acc = acc + ((w * r) >>> FRAC_SHIFT);
               leaked = (w * $signed({64'd0, leak_coef})) >>> LEAK_FRAC;
               grad = ((e * r) <<< GRAD_ALIGN) >>> step_shift;
               nw = leaked + grad;
               if (nw > WEIGHT_MAX) nw = WEIGHT_MAX;
               if (nw < WEIGHT_MIN) nw = WEIGHT_MIN;
               weights[i] = nw[WEIGHT_W-1:0];
            end
            for (int i = TB_TAP_COUNT - 1; i >= 1; i--) begin
               ref_line[i] = ref_line[i-1];
               err_line[i] = err_line[i-1];
            end
            // q.16 sum truncated toward zero
            if (acc < 0) res = -((-acc) >>> FRAC_SHIFT);
            else res = acc >>> FRAC_SHIFT;
            if (res > OUT_MAX) res = OUT_MAX;
            if (res < OUT_MIN) res = OUT_MIN;
            return res[SAMPLE_W-1:0];
         end else if (mode == MODE_PASS) begin
            return p.reference_sample;
         end
         return '0;
      endfunction

      function void note_request(req_payload_type p);
         expected_out.push_back(predict_out_sample(p));
      endfunction

      task check_response(rsp_payload_type p);
         logic signed [SAMPLE_W-1:0] want;
         if (expected_out.size() == 0) begin
            report($sformatf("unexpected response out_sample=%0d", p.out_sample));
         end else begin
            want = expected_out.pop_front();
            if (p.out_sample !== want)
               report($sformatf("out_sample got %0d want %0d", p.out_sample, want));
         end
      endtask

      function int pending();
         return expected_out.size();
      endfunction

      task check_drained();
         if (expected_out.size() != 0)
            report($sformatf("%0d responses never arrived", expected_out.size()));
      endtask
   endclass

endpackage

// ----- tb/leaky_lms_noise_canceller_tb.sv -----
// testbench of the leaky lms noise canceller: random and directed sample pairs, scoreboard check
module leaky_lms_noise_canceller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import llnc_pkg::*;
   import llnc_scoreboard_pkg::*;

   localparam int STALL_LIMIT    = 3000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 100;
   localparam int LONG_HOLD      = 400;

   logic clock;
   logic reset;

   int tx_idle_pct;
   int rx_idle_pct;
   int hold_cycles;

   anti_noise_scoreboard sb;

   llnc_stream_if #(.payload_type(req_payload_type)) req_chan ();
   llnc_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();
   llnc_stream_if #(.payload_type(csr_payload_type)) csr_chan ();

   leaky_lms_noise_canceller #(
      .TAP_COUNT(TB_TAP_COUNT)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source),
      .csr_chan(csr_chan.sink)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // transaction monitors feeding the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_chan.valid && csr_chan.ready) sb.write_reg(csr_chan.payload);
         if (req_chan.valid && req_chan.ready) sb.note_request(req_chan.payload);
         if (rsp_chan.valid && rsp_chan.ready) sb.check_response(rsp_chan.payload);
      end
   end

   // receiver: random back-pressure plus an occasional long hold-off
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // watchdog on cycles without any transaction
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready) || (csr_chan.valid && csr_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Verification failed");
      $finish;
   end

   // one request transaction; valid stays high into the next call when no gap follows
   task automatic send_pair(input logic signed [SAMPLE_W-1:0] ref_s,
                            input logic signed [SAMPLE_W-1:0] err_s);
      req_payload_type p;
      p.reference_sample = ref_s;
      p.error_sample     = err_s;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= p;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_payload_type p;
      p.index = idx;
      p.data  = data;
      csr_chan.valid   <= 1'b1;
      csr_chan.payload <= p;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
   endtask

   // wait for the block to go idle, then load all registers
   task automatic reconfigure(input logic [MODE_W-1:0] m, input logic [LEAK_W-1:0] leak,
                              input logic [SHIFT_W-1:0] step, input bit poke_unused);
      logic [CSR_DATA_W-1:0] d;
      while (sb.pending() > 0) @(posedge clock);
      repeat (TB_TAP_COUNT + 3) @(posedge clock);
      // upper bits of the narrow registers are don't-care
      d = $urandom();
      d[MODE_W-1:0] = m;
      write_csr(CSR_MODE, d);
      write_csr(CSR_LEAK, leak);
      d = $urandom();
      d[SHIFT_W-1:0] = step;
      write_csr(CSR_STEP, d);
      if (poke_unused) write_csr(CSR_UNUSED, $urandom());
      csr_chan.valid <= 1'b0;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int v;
      v = $urandom_range(9);
      case (v)
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2, 3: begin
            v = $urandom_range(255);
            return 16'(v - 128);
         end
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode();
      int v;
      v = $urandom_range(9);
      if (v < 6) return MODE_ADAPT;
      if (v < 8) return MODE_PASS;
      if (v == 8) return MODE_OFF;
      return MODE_SPARE;
   endfunction

   function automatic logic [LEAK_W-1:0] pick_leak();
      case ($urandom_range(4))
         0: return 16'd0;
         1: return 16'd32768;
         2: return 16'hffff;
         3: return 16'($urandom_range(32768));
         default: return 16'($urandom_range(32768, 30000));
      endcase
   endfunction

   function automatic logic [SHIFT_W-1:0] pick_step();
      case ($urandom_range(5))
         0: return 6'd0;
         1: return 6'd40;
         2: return 6'd63;
         default: return 6'($urandom_range(40, 20));
      endcase
   endfunction

   // main sequence
   initial begin
      sb = new();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_cycles = 0;
      reset = 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      csr_chan.valid   <= 1'b0;
      csr_chan.payload <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: register defaults, full-scale and small samples
      send_pair(16'sh7fff, 16'sh7fff);
      send_pair(16'sh8000, 16'sh8000);
      send_pair(16'sh8000, 16'sh7fff);
      send_pair(16'sh0000, 16'sh0000);
      send_pair(16'sh0001, 16'shffff);
      req_chan.valid <= 1'b0;

      // leak above one with no step shift drives weights and output into saturation
      reconfigure(MODE_ADAPT, 16'hffff, 6'd0, 1'b0);
      send_pair(16'sh7fff, 16'sh7fff);
      send_pair(16'sh7fff, 16'sh7fff);
      send_pair(16'sh7fff, 16'sh7fff);
      send_pair(16'sh8000, 16'sh8000);
      send_pair(16'sh8000, 16'sh8000);
      req_chan.valid <= 1'b0;

      // shift of 63: negative gradient terms floor to minus one
      reconfigure(MODE_ADAPT, 16'd32768, 6'd63, 1'b0);
      send_pair(16'shffff, 16'sh0001);
      send_pair(16'sh0005, -16'sd7);
      send_pair(16'sh8000, 16'sh7fff);
      req_chan.valid <= 1'b0;

      // passthrough and off modes, unused mode and unused register index
      reconfigure(MODE_PASS, 16'd16384, 6'd30, 1'b0);
      send_pair(16'sh8000, 16'sh0000);
      send_pair(16'sh7fff, 16'sh0001);
      send_pair(16'sd123, -16'sd5);
      req_chan.valid <= 1'b0;
      reconfigure(MODE_OFF, 16'd16384, 6'd30, 1'b0);
      send_pair(16'sh7fff, 16'sh8000);
      send_pair(16'shffff, 16'shffff);
      req_chan.valid <= 1'b0;
      reconfigure(MODE_SPARE, 16'd16384, 6'd30, 1'b1);
      send_pair(16'sd1000, 16'sd2000);
      req_chan.valid <= 1'b0;

      // back to adaptive after frozen modes, zero leak, step shift of 40
      reconfigure(MODE_ADAPT, 16'd0, 6'd40, 1'b0);
      send_pair(16'sd100, 16'sd200);
      send_pair(16'sh8000, 16'sh8000);
      send_pair(16'sh7fff, 16'sh8000);
      req_chan.valid <= 1'b0;

      // random phases with changing settings and idle patterns
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         reconfigure(pick_mode(), pick_leak(), pick_step(), (ph == 3));
         if (ph < 3) begin
            tx_idle_pct = 25;
            rx_idle_pct = 86;
         end else if (ph < 6) begin
            tx_idle_pct = 86;
            rx_idle_pct = 25;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         // long receiver hold-off so the block backs up into the request side
         if (ph == 0 || ph == 6) hold_cycles = LONG_HOLD;
         for (int n = 0; n < PHASE_ITEMS; n++) send_pair(pick_sample(), pick_sample());
         req_chan.valid <= 1'b0;
      end

      // drain and look for stray responses
      while (sb.pending() > 0) @(posedge clock);
      repeat (TB_TAP_COUNT + 10) @(posedge clock);
      sb.check_drained();
      if (sb.error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ----- leaky_lms_noise_canceller.f -----
+incdir+hdl
hdl/llnc_pkg.sv
hdl/llnc_stream_if.sv
hdl/llnc_cell.sv
hdl/llnc_update.sv
hdl/leaky_lms_noise_canceller.sv
tb/llnc_scoreboard_pkg.sv
tb/leaky_lms_noise_canceller_tb.sv
